FILE: sv/gcd_lcm_unit_top_assert.svh
// assertion macros for the gcd / lcm unit checker
`ifndef GCD_LCM_UNIT_TOP_ASSERT_SVH
`define GCD_LCM_UNIT_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GLU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcd_lcm_unit_top: assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define GLU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcd_lcm_unit_top: assertion failed");

`endif

FILE: sv/glu_pkg.sv
// package of types, constants and microcode addresses for the gcd / lcm unit
`timescale 1ns / 1ps
`default_nettype none

package glu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_W           = 32;
    localparam int RESULT_W          = 63;
    localparam int IN_TDATA_W        = 64;
    localparam int OUT_TDATA_W       = 64;
    localparam int PC_W              = 4;

    // microprogram addresses
    localparam logic [PC_W-1:0] ADDR_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ADDR_ZCHK  = 4'd1;
    localparam logic [PC_W-1:0] ADDR_GCD   = 4'd2;
    localparam logic [PC_W-1:0] ADDR_FIN   = 4'd3;
    localparam logic [PC_W-1:0] ADDR_DINIT = 4'd4;
    localparam logic [PC_W-1:0] ADDR_DSTEP = 4'd5;
    localparam logic [PC_W-1:0] ADDR_MUL   = 4'd6;
    localparam logic [PC_W-1:0] ADDR_SELG  = 4'd7;
    localparam logic [PC_W-1:0] ADDR_WRITE = 4'd8;
    localparam logic [PC_W-1:0] ADDR_BACK  = 4'd9;
    localparam logic [PC_W-1:0] ADDR_ZERO  = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_GCD,
        OP_FIN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL,
        OP_SEL_G,
        OP_ZERO,
        OP_WRITE
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_ACC,
        COND_ANY_ZERO,
        COND_X_NE_Y,
        COND_IS_GCD,
        COND_CNT_NOT_LAST,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl_word;

    typedef struct packed {
        logic any_zero;
        logic x_ne_y;
        logic is_gcd;
        logic cnt_last;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/glu_rom.sv
// control store of the gcd / lcm microprogram
`timescale 1ns / 1ps
`default_nettype none

module glu_rom (
    input  wire logic [glu_pkg::PC_W-1:0] i_pc,
    output glu_pkg::t_ctrl_word           o_word
);
    import glu_pkg::*;

    // jump to target when the condition holds, else fall through to pc + 1
    always_comb begin
        case (i_pc)
            ADDR_IDLE:  o_word = '{OP_LOAD,     COND_NOT_ACC,      ADDR_IDLE};
            ADDR_ZCHK:  o_word = '{OP_NOP,      COND_ANY_ZERO,     ADDR_ZERO};
            ADDR_GCD:   o_word = '{OP_GCD,      COND_X_NE_Y,       ADDR_GCD};
            ADDR_FIN:   o_word = '{OP_FIN,      COND_IS_GCD,       ADDR_SELG};
            ADDR_DINIT: o_word = '{OP_DIV_INIT, COND_NEVER,        ADDR_IDLE};
            ADDR_DSTEP: o_word = '{OP_DIV_STEP, COND_CNT_NOT_LAST, ADDR_DSTEP};
            ADDR_MUL:   o_word = '{OP_MUL,      COND_ALWAYS,       ADDR_WRITE};
            ADDR_SELG:  o_word = '{OP_SEL_G,    COND_NEVER,        ADDR_IDLE};
            ADDR_WRITE: o_word = '{OP_WRITE,    COND_OUT_BUSY,     ADDR_WRITE};
            ADDR_BACK:  o_word = '{OP_NOP,      COND_ALWAYS,       ADDR_IDLE};
            ADDR_ZERO:  o_word = '{OP_ZERO,     COND_ALWAYS,       ADDR_WRITE};
            default:    o_word = '{OP_NOP,      COND_ALWAYS,       ADDR_IDLE};
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/glu_datapath.sv
// datapath of the gcd / lcm unit: magnitudes, binary gcd, divider and multiplier
`timescale 1ns / 1ps
`default_nettype none

module glu_datapath #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire glu_pkg::t_op                  i_op,
    input  wire logic                          i_acc,
    input  wire logic                          i_cmd,
    input  wire logic [glu_pkg::FIELD_W-1:0]   i_a,
    input  wire logic [glu_pkg::FIELD_W-1:0]   i_b,
    output glu_pkg::t_status                   o_status,
    output logic [glu_pkg::RESULT_W-1:0]       o_res
);
    import glu_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    logic [W-1:0]    r_x, r_y, r_ma, r_mb, r_q, r_rem;
    logic [KW-1:0]   r_k, r_cnt;
    logic            r_cmd;
    logic [RESULT_W-1:0] r_res;

    logic [W-1:0]    a_low, b_low, mag_a, mag_b;
    logic [W:0]      rem_sh, rem_sub;
    logic            rem_ge;
    logic [2*W-1:0]  prod;

    assign a_low = i_a[W-1:0];
    assign b_low = i_b[W-1:0];
    // negation of the most negative value gives 2^(W-1) exactly as unsigned
    assign mag_a = a_low[W-1] ? (~a_low + W'(1)) : a_low;
    assign mag_b = b_low[W-1] ? (~b_low + W'(1)) : b_low;

    // one restoring division step: dividend bits come from the top of r_q
    assign rem_sh  = {r_rem, r_q[W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_x};
    assign rem_sub = rem_sh - {1'b0, r_x};

    assign prod = r_q * r_mb;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_acc) begin
                    r_x   <= mag_a;
                    r_y   <= mag_b;
                    r_ma  <= mag_a;
                    r_mb  <= mag_b;
                    r_cmd <= i_cmd;
                    r_k   <= '0;
                end
            end
            OP_GCD: begin
                if (r_x != r_y) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= r_x - r_y;
                    end else begin
                        r_y <= r_y - r_x;
                    end
                end
            end
            OP_FIN: begin
                r_x <= r_x << r_k;
            end
            OP_DIV_INIT: begin
                r_q   <= r_ma;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                r_q   <= {r_q[W-2:0], rem_ge};
                r_cnt <= r_cnt + KW'(1);
            end
            OP_MUL: begin
                r_res <= RESULT_W'(prod);
            end
            OP_SEL_G: begin
                r_res <= RESULT_W'(r_x);
            end
            OP_ZERO: begin
                // one operand is zero: gcd is the other magnitude, lcm is zero
                r_res <= r_cmd ? '0 : RESULT_W'(r_x | r_y);
            end
            default: begin
            end
        endcase
    end

    assign o_status.any_zero = (r_x == '0) || (r_y == '0);
    assign o_status.x_ne_y   = r_x != r_y;
    assign o_status.is_gcd   = !r_cmd;
    assign o_status.cnt_last = r_cnt == KW'(W - 1);
    assign o_res             = r_res;

endmodule

`default_nettype wire

FILE: sv/gcd_lcm_unit_top.sv
// top level of the gcd / lcm unit: microcode sequencer, datapath and output register
//
// usage:
//   slave stream carries one transaction per item: tdata holds operand_a in
//   bits 31:0 and operand_b in bits 63:32, tuser holds the command
//   (0 gcd, 1 lcm). only the low OPERAND_WIDTH bits of each operand count
//   master stream returns one transaction per item, result in tdata 62:0
//   steps per item: accept at idle, zero check, the binary gcd loop and
//   the finish shift; then gcd selects the result while lcm runs the
//   divider and the multiplier. a zero operand goes from the zero check
//   to the zero step. after the write the back step returns to idle
//   rate is set by the gcd loop and the one-bit-per-cycle restoring divider,
//   both sequenced by the microprogram
//   s_tready is high only out of reset while the sequencer sits at its idle
//   step; a new item may be taken while the previous result still waits in
//   the output register
//   a stalled receiver holds the result; the sequencer waits at its write
//   step until the output register is free
//   synchronous active-low reset clears the step counter and output valid
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit_top #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [glu_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // operand_a, operand_b
    input  wire logic                              i_s_tuser,  // command
    // master stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [glu_pkg::OUT_TDATA_W-1:0]        o_m_tdata   // result, zero pad
);
    import glu_pkg::*;

    logic [PC_W-1:0]     r_pc, n_pc;
    t_ctrl_word          ctrl;
    t_status             status;
    logic                in_acc;
    logic                cond_hit;
    logic [RESULT_W-1:0] dp_res;
    logic                r_out_valid;
    logic [RESULT_W-1:0] r_out_data;

    // no transaction is taken while reset is held
    assign o_s_tready = i_rst_n && (r_pc == ADDR_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;

    glu_rom u_rom (
        .i_pc   (r_pc),
        .o_word (ctrl)
    );

    glu_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_op     (ctrl.op),
        .i_acc    (in_acc),
        .i_cmd    (i_s_tuser),
        .i_a      (i_s_tdata[FIELD_W-1:0]),
        .i_b      (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .o_status (status),
        .o_res    (dp_res)
    );

    // condition select for the conditional jump
    always_comb begin
        case (ctrl.cond)
            COND_NEVER:        cond_hit = 1'b0;
            COND_ALWAYS:       cond_hit = 1'b1;
            COND_NOT_ACC:      cond_hit = !in_acc;
            COND_ANY_ZERO:     cond_hit = status.any_zero;
            COND_X_NE_Y:       cond_hit = status.x_ne_y;
            COND_IS_GCD:       cond_hit = status.is_gcd;
            COND_CNT_NOT_LAST: cond_hit = !status.cnt_last;
            COND_OUT_BUSY:     cond_hit = r_out_valid;
            default:           cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? ctrl.target : r_pc + PC_W'(1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ADDR_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // output register: loaded at the write step only when empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_WRITE && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_WRITE && !r_out_valid) begin
            r_out_data <= dp_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

`default_nettype wire

FILE: sv/glu_checker.sv
// port-level assertion checker for the gcd / lcm unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "gcd_lcm_unit_top_assert.svh"

module glu_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic [glu_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input wire logic                           i_s_tuser,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [glu_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import glu_pkg::*;

    logic in_acc;
    logic out_stall;
    logic in_seen;

    assign in_acc    = i_s_tvalid && o_s_tready;
    assign out_stall = o_m_tvalid && !i_m_tready;
    assign in_seen   = in_acc && (i_s_tuser || !i_s_tuser) && (i_s_tdata == i_s_tdata);

    // a stalled result stays offered and unchanged
    `GLU_ASSERT_NEXT(a_out_hold, out_stall, o_m_tvalid)
    `GLU_ASSERT_NEXT(a_out_stable, out_stall, $stable(o_m_tdata))
    // an accepted item closes the input behind it
    `GLU_ASSERT_NEXT(a_busy_after_accept, in_seen, !o_s_tready)
    // the padding bit above the result never carries data
    `GLU_ASSERT_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[OUT_TDATA_W-1] == 1'b0)

endmodule

bind gcd_lcm_unit_top glu_checker u_glu_checker (.*);

`default_nettype wire
